### design/opd_pkg.sv
package opd_pkg;

    // Field widths fixed by the interface
    localparam int COEF_W     = 32;
    localparam int VAR_W      = 16;
    localparam int EXP_W      = 3;
    localparam int EXP_PACK_W = 4 * EXP_W;
    localparam int CNT_CFG_W  = 7;
    localparam int IDX_W      = 6;
    localparam int DELTA_W    = 32;

    // Term value: signed Q15.32
    localparam int PROD_W     = 48;
    localparam int MUL_W      = PROD_W + VAR_W;
    localparam int COEF_SHIFT = 8;
    localparam int MUL_SHIFT  = 8;
    localparam int OUT_SHIFT  = 16;

    // Rounding offsets (half up)
    localparam logic signed [MUL_W-1:0] MUL_HALF = MUL_W'(1) <<< (MUL_SHIFT - 1);

    // Clamp values
    localparam logic signed [PROD_W-1:0] PROD_MAX  = {1'b0, {(PROD_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] PROD_MIN  = {1'b1, {(PROD_W-1){1'b0}}};
    localparam logic signed [DELTA_W-1:0] DELTA_MAX = {1'b0, {(DELTA_W-1){1'b1}}};
    localparam logic signed [DELTA_W-1:0] DELTA_MIN = {1'b1, {(DELTA_W-1){1'b0}}};

    // Action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    // One term travelling down the cell chain
    typedef struct packed {
        logic                     valid;
        logic                     last;
        logic                     sat;
        logic signed [PROD_W-1:0] t;
        logic [EXP_PACK_W-1:0]    expo;
    } t_term;

endpackage

### design/opd_term_mem.sv
module opd_term_mem import opd_pkg::*; #(
    parameter int MAX_TERMS = 64,
    parameter int AW        = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_wr_en,
    input  logic [AW-1:0]           i_wr_addr,
    input  logic [COEF_W-1:0]       i_wr_coef,
    input  logic [EXP_PACK_W-1:0]   i_wr_expo,
    input  logic                    i_rd_en,
    input  logic                    i_rd_last,
    input  logic [AW-1:0]           i_rd_addr,
    output t_term                   o_term
);

    localparam int WORD_W = COEF_W + EXP_PACK_W;

    logic [WORD_W-1:0] r_mem [MAX_TERMS];
    logic [WORD_W-1:0] r_rd_word;
    logic              r_rd_valid;
    logic              r_rd_last;

    // Write one term word
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_coef, i_wr_expo};
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        r_rd_word <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_rd_last  <= 1'b0;
        end else begin
            r_rd_valid <= i_rd_en;
            r_rd_last  <= i_rd_en & i_rd_last;
        end
    end

    // Start the term as coefficient in Q15.32
    always_comb begin
        o_term.valid = r_rd_valid;
        o_term.last  = r_rd_last;
        o_term.sat   = 1'b0;
        o_term.t     = PROD_W'($signed(r_rd_word[WORD_W-1 -: COEF_W])) <<< COEF_SHIFT;
        o_term.expo  = r_rd_word[EXP_PACK_W-1:0];
    end

endmodule

### design/opd_cell.sv
module opd_cell import opd_pkg::*; #(
    parameter int VAR_SEL = 0,
    parameter int STEP    = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_term                   i_term,
    input  logic signed [VAR_W-1:0] i_var,
    output t_term                   o_term
);

    localparam logic [EXP_W:0] STEP_C = (EXP_W + 1)'(STEP);

    t_term                    r_term;
    t_term                    n_term;
    logic                     active;
    logic signed [MUL_W-1:0]  prod;
    logic signed [MUL_W-1:0]  shifted;
    logic                     in_range;

    // Multiply only while this step is below the term's exponent
    assign active = {1'b0, i_term.expo[EXP_W*VAR_SEL +: EXP_W]} > STEP_C;

    assign prod     = i_term.t * i_var;
    assign shifted  = (prod + MUL_HALF) >>> MUL_SHIFT;
    assign in_range = shifted[MUL_W-1:PROD_W-1] == {(MUL_W-PROD_W+1){shifted[PROD_W-1]}};

    always_comb begin
        n_term = i_term;
        if (active) begin
            if (in_range) begin
                n_term.t = shifted[PROD_W-1:0];
            end else begin
                n_term.t   = shifted[MUL_W-1] ? PROD_MIN : PROD_MAX;
                n_term.sat = 1'b1;
            end
        end
    end

    // Hand the term to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term.valid <= 1'b0;
            r_term.last  <= 1'b0;
        end else begin
            r_term.valid <= n_term.valid;
            r_term.last  <= n_term.valid & n_term.last;
        end
        r_term.sat  <= n_term.sat;
        r_term.t    <= n_term.t;
        r_term.expo <= n_term.expo;
    end

    assign o_term = r_term;

endmodule

### design/opd_accum.sv
module opd_accum import opd_pkg::*; #(
    parameter int ACC_W = 55
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_empty,
    input  t_term                     i_term,
    output logic                      o_busy,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [DELTA_W-1:0] o_delta,
    output logic                      o_saturated
);

    localparam int RND_W = ACC_W + 1 - OUT_SHIFT;
    localparam logic signed [ACC_W:0] ACC_HALF = (ACC_W + 1)'(1) <<< (OUT_SHIFT - 1);

    typedef enum logic [1:0] {S_IDLE, S_ACC, S_RND, S_PUT} t_state;

    t_state                     r_state;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_sat;
    logic signed [RND_W-1:0]    r_rnd;
    logic                       r_out_valid;
    logic signed [DELTA_W-1:0]  r_delta;
    logic                       r_saturated;
    logic signed [ACC_W:0]      rnd_sum;
    logic                       rnd_ok;
    logic                       out_free;

    assign rnd_sum  = (ACC_W + 1)'(r_acc) + ACC_HALF;
    assign rnd_ok   = r_rnd[RND_W-1:DELTA_W-1] == {(RND_W-DELTA_W+1){r_rnd[DELTA_W-1]}};
    assign out_free = !r_out_valid || !i_out_stall;

    // Sum terms, round, clamp, and hold the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_PUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_acc   <= '0;
                        r_sat   <= 1'b0;
                        r_state <= i_empty ? S_RND : S_ACC;
                    end
                end
                S_ACC: begin
                    if (i_term.valid) begin
                        r_acc <= r_acc + ACC_W'(i_term.t);
                        r_sat <= r_sat | i_term.sat;
                        if (i_term.last) begin
                            r_state <= S_RND;
                        end
                    end
                end
                S_RND: begin
                    r_rnd   <= RND_W'(rnd_sum >>> OUT_SHIFT);
                    r_state <= S_PUT;
                end
                S_PUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_delta     <= rnd_ok ? r_rnd[DELTA_W-1:0]
                                              : (r_rnd[RND_W-1] ? DELTA_MIN : DELTA_MAX);
                        r_saturated <= r_sat | !rnd_ok;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_delta     = r_delta;
    assign o_saturated = r_saturated;

endmodule

### design/optics_polynomial_delta.sv
// Four-variable polynomial evaluator. A load word (action 0) writes one term,
// a coefficient and four exponents, into slot term_index; slots at or above
// MAX_TERMS are dropped. An evaluate word (action 1) sums the first
// min(term_count, MAX_TERMS) terms for the track (x, y, a, b) and returns one
// delta word with a saturation flag. Terms stream out of the term memory at one
// per cycle into a chain of 4*MAX_EXP multiply cells, one cell per possible
// power, whose last cell feeds the accumulator. One item is worked on at a time.
// A finished delta waits in an output register while the next word is taken.
// The term memory is not cleared: evaluate only over slots that were loaded.
module optics_polynomial_delta import opd_pkg::*; #(
    parameter int MAX_TERMS = 64,
    parameter int MAX_EXP   = 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CNT_CFG_W-1:0]      i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_action,
    input  logic [IDX_W-1:0]          i_term_index,
    input  logic signed [COEF_W-1:0]  i_coefficient,
    input  logic [EXP_W-1:0]          i_exp_x,
    input  logic [EXP_W-1:0]          i_exp_y,
    input  logic [EXP_W-1:0]          i_exp_a,
    input  logic [EXP_W-1:0]          i_exp_b,
    input  logic signed [VAR_W-1:0]   i_pos_x,
    input  logic signed [VAR_W-1:0]   i_pos_y,
    input  logic signed [VAR_W-1:0]   i_angle_a,
    input  logic signed [VAR_W-1:0]   i_angle_b,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [DELTA_W-1:0] o_delta,
    output logic                      o_saturated
);

    localparam int AW     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW_RAW = $clog2(MAX_TERMS + 1);
    localparam int CW     = (CW_RAW > CNT_CFG_W) ? CW_RAW : CNT_CFG_W;
    localparam int NCELL  = 4 * MAX_EXP;
    localparam int ACC_W  = PROD_W + CW_RAW;

    typedef enum logic {T_IDLE, T_ISSUE} t_state;

    t_state                  r_state;
    logic [CNT_CFG_W-1:0]    r_term_count;
    logic [CW-1:0]           r_n;
    logic [AW-1:0]           r_addr;
    logic signed [VAR_W-1:0] r_var [4];

    logic          acc_busy;
    logic          engine_idle;
    logic          accept;
    logic          eval_go;
    logic [CW-1:0] idx_ext;
    logic [CW-1:0] n_eff;
    logic          wr_en;
    logic          rd_last;
    t_term         chain [NCELL+1];

    assign engine_idle = (r_state == T_IDLE) && !acc_busy;
    assign o_in_stall  = !engine_idle;
    assign accept      = i_in_valid && engine_idle;
    assign eval_go     = accept && (i_action == ACT_EVAL);

    // Clamp the term count to the memory depth
    assign n_eff = (CW'(r_term_count) < CW'(MAX_TERMS)) ? CW'(r_term_count) : CW'(MAX_TERMS);

    // Drop loads aimed past the memory
    assign idx_ext = CW'(i_term_index);
    assign wr_en   = accept && (i_action == ACT_LOAD) && (idx_ext < CW'(MAX_TERMS));
    assign rd_last = (CW'(r_addr) + CW'(1)) == r_n;

    assign o_cfg_ready = 1'b1;

    // Hold the term count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_term_count <= i_cfg_data;
        end
    end

    // Issue one memory read per cycle for the terms in use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
        end else begin
            case (r_state)
                T_IDLE: begin
                    if (eval_go) begin
                        r_n      <= n_eff;
                        r_addr   <= '0;
                        r_var[0] <= i_pos_x;
                        r_var[1] <= i_pos_y;
                        r_var[2] <= i_angle_a;
                        r_var[3] <= i_angle_b;
                        if (n_eff != '0) begin
                            r_state <= T_ISSUE;
                        end
                    end
                end
                T_ISSUE: begin
                    r_addr <= r_addr + AW'(1);
                    if (rd_last) begin
                        r_state <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    opd_term_mem #(
        .MAX_TERMS (MAX_TERMS),
        .AW        (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (idx_ext[AW-1:0]),
        .i_wr_coef (i_coefficient),
        .i_wr_expo ({i_exp_b, i_exp_a, i_exp_y, i_exp_x}),
        .i_rd_en   (r_state == T_ISSUE),
        .i_rd_last (rd_last),
        .i_rd_addr (r_addr),
        .o_term    (chain[0])
    );

    // One cell per possible power of each variable
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        localparam int VSEL = k / MAX_EXP;
        localparam int STP  = k % MAX_EXP;
        opd_cell #(
            .VAR_SEL (VSEL),
            .STEP    (STP)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_term  (chain[k]),
            .i_var   (r_var[VSEL]),
            .o_term  (chain[k+1])
        );
    end

    opd_accum #(
        .ACC_W (ACC_W)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (eval_go),
        .i_empty     (n_eff == '0),
        .i_term      (chain[NCELL]),
        .o_busy      (acc_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_delta     (o_delta),
        .o_saturated (o_saturated)
    );

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import opd_pkg::*;

    localparam int SLOTS         = 64;
    localparam int SETTLE_CYCLES = 120;
    localparam int IDLE_LIMIT    = 4000;
    localparam int REPORT_MAX    = 10;
    localparam int PHASES        = 10;
    localparam int PHASE_WORDS   = 62;

    // One input word as it appears on the port
    typedef struct {
        logic                     action;
        logic [IDX_W-1:0]         slot;
        logic signed [COEF_W-1:0] coef;
        logic [EXP_W-1:0]         ex;
        logic [EXP_W-1:0]         ey;
        logic [EXP_W-1:0]         ea;
        logic [EXP_W-1:0]         eb;
        logic signed [VAR_W-1:0]  px;
        logic signed [VAR_W-1:0]  py;
        logic signed [VAR_W-1:0]  aa;
        logic signed [VAR_W-1:0]  ab;
    } t_track_word;

    // One delta word the block should return
    typedef struct {
        logic signed [DELTA_W-1:0] delta;
        logic                      sat;
    } t_delta_rec;

    logic                      i_clk;
    logic                      i_rst_n       = 1'b0;
    logic                      i_cfg_valid   = 1'b0;
    logic                      o_cfg_ready;
    logic [CNT_CFG_W-1:0]      i_cfg_data    = '0;
    logic                      i_in_valid    = 1'b0;
    logic                      o_in_stall;
    logic                      i_action      = ACT_LOAD;
    logic [IDX_W-1:0]          i_term_index  = '0;
    logic signed [COEF_W-1:0]  i_coefficient = '0;
    logic [EXP_W-1:0]          i_exp_x       = '0;
    logic [EXP_W-1:0]          i_exp_y       = '0;
    logic [EXP_W-1:0]          i_exp_a       = '0;
    logic [EXP_W-1:0]          i_exp_b       = '0;
    logic signed [VAR_W-1:0]   i_pos_x       = '0;
    logic signed [VAR_W-1:0]   i_pos_y       = '0;
    logic signed [VAR_W-1:0]   i_angle_a     = '0;
    logic signed [VAR_W-1:0]   i_angle_b     = '0;
    logic                      o_out_valid;
    logic                      i_out_stall   = 1'b0;
    logic signed [DELTA_W-1:0] o_delta;
    logic                      o_saturated;

    // Shadow copy of the term memory and the count register
    logic signed [COEF_W-1:0]  term_coef [SLOTS];
    logic [EXP_PACK_W-1:0]     term_expo [SLOTS];
    int                        count_setting = 0;
    bit                        term_clamped;

    t_delta_rec                pending_deltas [$];
    int                        mismatches    = 0;
    int                        idle_run      = 0;
    int                        stall_left    = 0;
    int                        gap_odds      = 4;
    int                        stall_odds    = 6;
    bit                        quiet         = 1'b0;

    optics_polynomial_delta dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_term_index  (i_term_index),
        .i_coefficient (i_coefficient),
        .i_exp_x       (i_exp_x),
        .i_exp_y       (i_exp_y),
        .i_exp_a       (i_exp_a),
        .i_exp_b       (i_exp_b),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_angle_a     (i_angle_a),
        .i_angle_b     (i_angle_b),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_delta       (o_delta),
        .o_saturated   (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Raise t by one variable: round half up after each multiply, clamp to Q15.32
    function automatic longint apply_power(longint t, longint v, int e);
        longint p;
        for (int k = 0; k < e; k++) begin
            p = (t * v + 128) >>> MUL_SHIFT;
            if (p > longint'(PROD_MAX)) begin
                p = longint'(PROD_MAX);
                term_clamped = 1'b1;
            end else if (p < longint'(PROD_MIN)) begin
                p = longint'(PROD_MIN);
                term_clamped = 1'b1;
            end
            t = p;
        end
        return t;
    endfunction

    // Sum the active terms for one track and round to Q16.16
    function automatic t_delta_rec predict_delta(t_track_word w);
        t_delta_rec            r;
        longint                acc;
        longint                t;
        longint                d;
        int                    n;
        logic [EXP_PACK_W-1:0] e;
        term_clamped = 1'b0;
        acc = 0;
        n = (count_setting > SLOTS) ? SLOTS : count_setting;
        for (int i = 0; i < n; i++) begin
            e = term_expo[i];
            t = longint'(term_coef[i]) * 256;
            t = apply_power(t, longint'(w.px), int'(e[2:0]));
            t = apply_power(t, longint'(w.py), int'(e[5:3]));
            t = apply_power(t, longint'(w.aa), int'(e[8:6]));
            t = apply_power(t, longint'(w.ab), int'(e[11:9]));
            acc += t;
        end
        d = (acc + 32768) >>> OUT_SHIFT;
        if (d > longint'(DELTA_MAX)) begin
            d = longint'(DELTA_MAX);
            term_clamped = 1'b1;
        end else if (d < longint'(DELTA_MIN)) begin
            d = longint'(DELTA_MIN);
            term_clamped = 1'b1;
        end
        r.delta = d[DELTA_W-1:0];
        r.sat   = term_clamped;
        return r;
    endfunction

    function automatic t_track_word load_word(int slot, logic signed [COEF_W-1:0] c,
                                              int ex, int ey, int ea, int eb);
        t_track_word w;
        w.action = ACT_LOAD;
        w.slot   = IDX_W'(slot);
        w.coef   = c;
        w.ex     = EXP_W'(ex);
        w.ey     = EXP_W'(ey);
        w.ea     = EXP_W'(ea);
        w.eb     = EXP_W'(eb);
        // track fields are don't-care on a load, so fill them with noise
        w.px     = VAR_W'($urandom);
        w.py     = VAR_W'($urandom);
        w.aa     = VAR_W'($urandom);
        w.ab     = VAR_W'($urandom);
        return w;
    endfunction

    function automatic t_track_word eval_word(logic signed [VAR_W-1:0] x,
                                              logic signed [VAR_W-1:0] y,
                                              logic signed [VAR_W-1:0] a,
                                              logic signed [VAR_W-1:0] b);
        t_track_word w;
        w.action = ACT_EVAL;
        w.slot   = IDX_W'($urandom);
        w.coef   = COEF_W'($urandom);
        w.ex     = EXP_W'($urandom);
        w.ey     = EXP_W'($urandom);
        w.ea     = EXP_W'($urandom);
        w.eb     = EXP_W'($urandom);
        w.px     = x;
        w.py     = y;
        w.aa     = a;
        w.ab     = b;
        return w;
    endfunction

    // Track value: mostly near unity so products neither vanish nor all clamp
    function automatic logic signed [VAR_W-1:0] pick_var();
        case ($urandom_range(0, 4))
            0: return VAR_W'($urandom);
            1, 2: return VAR_W'(int'($urandom_range(0, 1024)) - 512);
            3: return VAR_W'(int'($urandom_range(0, 128)) - 64);
            default: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh7fff;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    default: return 16'sh0100;
                endcase
            end
        endcase
    endfunction

    function automatic logic signed [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 3))
            0: return COEF_W'($urandom);
            1: return COEF_W'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
            2: return COEF_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7fffffff;
                    1: return 32'sh80000000;
                    2: return 32'sh00000000;
                    default: return 32'sh01000000;
                endcase
            end
        endcase
    endfunction

    task automatic flag_error(string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Send one word, with an optional idle burst ahead of it; update the shadow on accept
    task automatic send_word(t_track_word w);
        if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_action      <= w.action;
        i_term_index  <= w.slot;
        i_coefficient <= w.coef;
        i_exp_x       <= w.ex;
        i_exp_y       <= w.ey;
        i_exp_a       <= w.ea;
        i_exp_b       <= w.eb;
        i_pos_x       <= w.px;
        i_pos_y       <= w.py;
        i_angle_a     <= w.aa;
        i_angle_b     <= w.ab;
        i_in_valid    <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        if (w.action == ACT_LOAD) begin
            term_coef[w.slot] = w.coef;
            term_expo[w.slot] = {w.eb, w.ea, w.ey, w.ex};
        end else begin
            pending_deltas = {pending_deltas, predict_delta(w)};
        end
    endtask

    // Drop valid, drain all deltas, then give the block time to finish a load
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_deltas.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(int value);
        i_cfg_data  <= CNT_CFG_W'(value);
        i_cfg_valid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        count_setting = value;
    endtask

    // Count of zero straight out of reset: no term is read, delta is zero
    task automatic test_empty_table();
        send_word(eval_word(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000));
        send_word(eval_word(pick_var(), pick_var(), pick_var(), pick_var()));
        settle();
    endtask

    // One term: plain coefficient, unit powers, and per-multiply clamping
    task automatic test_single_term();
        write_count(1);
        send_word(load_word(0, 32'sh01000000, 0, 0, 0, 0));
        send_word(eval_word(pick_var(), pick_var(), pick_var(), pick_var()));
        send_word(load_word(0, 32'sh01000000, 1, 1, 1, 1));
        send_word(eval_word(16'sh0100, 16'sh0100, 16'sh0100, 16'sh0100));
        send_word(eval_word(-16'sh0100, 16'sh0200, 16'sh0080, -16'sh0180));
        send_word(load_word(0, 32'sh7fffffff, 7, 0, 0, 0));
        send_word(eval_word(16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0000));
        send_word(load_word(0, 32'sh80000000, 7, 7, 7, 7));
        send_word(eval_word(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
        settle();
    endtask

    // Final half-up rounding at the Q16.16 boundary, both signs
    task automatic test_rounding();
        send_word(load_word(0, 32'sd128, 0, 0, 0, 0));
        send_word(eval_word(pick_var(), pick_var(), pick_var(), pick_var()));
        send_word(load_word(0, -32'sd128, 0, 0, 0, 0));
        send_word(eval_word(pick_var(), pick_var(), pick_var(), pick_var()));
        send_word(load_word(0, 32'sd127, 0, 0, 0, 0));
        send_word(eval_word(pick_var(), pick_var(), pick_var(), pick_var()));
        send_word(load_word(0, -32'sd129, 0, 0, 0, 0));
        send_word(eval_word(pick_var(), pick_var(), pick_var(), pick_var()));
        settle();
    endtask

    // Fill every slot so the sum overflows delta; also a count above the table size
    task automatic test_full_table();
        for (int s = 0; s < SLOTS; s++)
            send_word(load_word(s, 32'sh7fffffff, 1, 0, 0, 0));
        settle();
        write_count(SLOTS);
        send_word(eval_word(16'sh7fff, 16'sh0100, 16'sh0100, 16'sh0100));
        send_word(eval_word(16'sh8000, 16'sh0100, 16'sh0100, 16'sh0100));
        send_word(eval_word(16'sh0000, pick_var(), pick_var(), pick_var()));
        settle();
        write_count(127);
        send_word(eval_word(16'sh7fff, pick_var(), pick_var(), pick_var()));
        settle();
    endtask

    // Phases of mixed loads and evaluations, each with its own count and idling
    task automatic test_random_mix();
        int cnt;
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: cnt = 0;
                1: cnt = SLOTS;
                2: cnt = 127;
                default: cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(13, SLOTS)
                                                           : $urandom_range(1, 12);
            endcase
            write_count(cnt);
            quiet = (ph >= PHASES - 2);
            case ($urandom_range(0, 3))
                0: gap_odds = 0;
                1: gap_odds = 2;
                2: gap_odds = 4;
                default: gap_odds = 8;
            endcase
            case ($urandom_range(0, 3))
                0: stall_odds = 0;
                1: stall_odds = 2;
                2: stall_odds = 6;
                default: stall_odds = 12;
            endcase
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if ($urandom_range(0, 3) == 0)
                    send_word(load_word($urandom_range(0, SLOTS - 1), pick_coef(),
                                        $urandom_range(0, 7), $urandom_range(0, 7),
                                        $urandom_range(0, 7), $urandom_range(0, 7)));
                else
                    send_word(eval_word(pick_var(), pick_var(), pick_var(), pick_var()));
            end
        end
    endtask

    // Hold the result side off in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            if (!quiet && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
                stall_left <= $urandom_range(1, 15);
        end
    end

    // Compare each accepted delta word with the oldest prediction
    always @(posedge i_clk) begin
        t_delta_rec want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_deltas.size() == 0) begin
                flag_error($sformatf("unexpected delta word: delta=%0d sat=%0b",
                                     o_delta, o_saturated));
            end else begin
                want = pending_deltas.pop_front();
                if (o_delta !== want.delta)
                    flag_error($sformatf("delta mismatch: expected %0d, got %0d",
                                         want.delta, o_delta));
                if (o_saturated !== want.sat)
                    flag_error($sformatf("saturated mismatch: expected %0b, got %0b",
                                         want.sat, o_saturated));
            end
        end
    end

    // End the run when no channel moves a word for too long
    initial begin
        while (idle_run < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("optics_polynomial_delta verification failed");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_single_term();
        test_rounding();
        test_full_table();
        test_random_mix();
        settle();
        if (mismatches == 0 && pending_deltas.size() == 0)
            $display("optics_polynomial_delta verification clean");
        else
            $display("optics_polynomial_delta verification failed");
        $finish;
    end

endmodule
